[hdl/esp_pkg.sv]
// shared types, constants and register indexes of the encoder poll sequencer
package esp_pkg;

    localparam int FIFO_DEPTH_DEF = 32;
    localparam int OQ_DEPTH       = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_SPEED_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_SPEED_RIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_COUNT_LEFT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_COUNT_RIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE     = 3'd6;

    localparam logic       MODE_TICK    = 1'b0;
    localparam logic       MODE_RX      = 1'b1;
    localparam logic       KIND_TX      = 1'b0;
    localparam logic       KIND_READING = 1'b1;
    localparam logic [7:0] BYTE_NO_MASK = 8'hFF;
    localparam logic [7:0] MASK_7BIT    = 8'h7F;
    localparam logic [15:0] IDLE_MAX    = 16'hFFFF;

    localparam logic [1:0] PUSH_NONE = 2'd0;
    localparam logic [1:0] PUSH_ONE  = 2'd1;
    localparam logic [1:0] PUSH_TWO  = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic [1:0]         reading_kind;
        logic signed [31:0] reading_value;
        logic [7:0]         status_byte;
        logic               checksum_ok;
        logic               overflow_seen;
        logic               last;
    } t_out_item;

    // per-cell control inside the receive chain
    typedef struct packed {
        logic load;
        logic shift5;
        logic shift6;
    } t_cell_ctl;

    // sequencer to receive chain
    typedef struct packed {
        logic       push;
        logic       pop5;
        logic       pop6;
        logic [7:0] rx_byte;
    } t_chain_ctl;

    // receive chain fill status back to the sequencer
    typedef struct packed {
        logic full;
        logic have5;
        logic have6;
    } t_chain_sts;

endpackage

[hdl/encoder_poll_sequencer_top.sv]
// top level of the encoder poll sequencer: step control, reply decode and ports
//
// Takes one item per clock while the result queue has room. A received byte goes into the
// receive chain (dropped if full) and gives no result; a tick on a request step gives two
// transmit bytes, a tick on a wait step with a full reply gives one reading, otherwise it
// advances the idle count and, at the timeout, the step. Results leave through a four-entry
// queue at one per clock while the output is ready, and the input is held off while more
// than two results are waiting. A poll pass where every wait tick finds its reply gives
// three results for two ticks, so such traffic is bounded by that single output port; bytes
// and idle wait ticks go through at one per clock while the queue has room. No clearing pass after reset.
module encoder_poll_sequencer_top #(
    parameter int FIFO_DEPTH = esp_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [esp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  esp_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output esp_pkg::t_out_item                  o_out_data
);
    import esp_pkg::*;

    logic [7:0]  r_addr;
    logic [6:0]  r_cmd_sl;
    logic [6:0]  r_cmd_sr;
    logic [6:0]  r_cmd_cl;
    logic [6:0]  r_cmd_cr;
    logic [15:0] r_timeout;
    logic        r_mask_en;

    logic [2:0]  r_step;
    logic [15:0] r_idle;
    logic        r_drop;
    logic [2:0]  n_step;
    logic [15:0] n_idle;
    logic        n_drop;

    t_chain_ctl      w_chain_ctl;
    t_chain_sts      w_chain_sts;
    logic [5:0][7:0] w_head;
    logic [5:0][7:0] w_b;
    logic [1:0]      w_push_n;
    t_out_item       w_res0;
    t_out_item       w_res1;
    logic            w_space;
    logic            w_acc;
    logic [1:0]      w_which;
    logic [6:0]      w_cmd;
    logic            w_is_count;
    logic            w_have;
    logic [7:0]      w_status;
    logic [6:0]      w_sum;
    logic [7:0]      w_csum;
    logic [15:0]     w_idle_inc;

    assign o_in_ready = w_space;
    assign w_acc      = i_in_valid && w_space;
    assign w_which    = r_step[2:1];
    assign w_is_count = w_which[1];
    assign w_have     = w_is_count ? w_chain_sts.have6 : w_chain_sts.have5;

    always_comb begin
        case (w_which)
            2'd0:    w_cmd = r_cmd_sl;
            2'd1:    w_cmd = r_cmd_sr;
            2'd2:    w_cmd = r_cmd_cl;
            default: w_cmd = r_cmd_cr;
        endcase
    end

    // when enabled, masking applies to the whole reply unless its first byte is 0xff
    always_comb begin
        w_b = w_head;
        if (r_mask_en && (w_head[0] != BYTE_NO_MASK)) begin
            for (int k = 0; k < 6; k++) begin
                w_b[k] = w_head[k] & MASK_7BIT;
            end
        end
    end

    assign w_status = w_is_count ? w_b[4] : 8'h00;
    assign w_sum    = r_addr[6:0] + w_cmd + w_b[0][6:0] + w_b[1][6:0]
                    + w_b[2][6:0] + w_b[3][6:0] + w_status[6:0];
    assign w_csum   = w_is_count ? w_b[5] : w_b[4];
    assign w_idle_inc = (r_idle < IDLE_MAX) ? r_idle + 16'd1 : r_idle;

    always_comb begin
        n_step      = r_step;
        n_idle      = r_idle;
        n_drop      = r_drop;
        w_chain_ctl = '0;
        w_chain_ctl.rx_byte = i_in_data.rx_byte;
        w_push_n    = PUSH_NONE;
        w_res0      = '0;
        w_res1      = '0;
        if (w_acc) begin
            if (i_in_data.mode == MODE_RX) begin
                if (w_chain_sts.full) begin
                    n_drop = 1'b1;
                end else begin
                    w_chain_ctl.push = 1'b1;
                end
            end else if (!r_step[0]) begin
                w_res0.kind    = KIND_TX;
                w_res0.tx_byte = r_addr;
                w_res1.kind    = KIND_TX;
                w_res1.tx_byte = {1'b0, w_cmd};
                w_res1.last    = 1'b1;
                w_push_n       = PUSH_TWO;
                n_step         = r_step + 3'd1;
                n_idle         = '0;
            end else if (w_have) begin
                w_chain_ctl.pop5     = !w_is_count;
                w_chain_ctl.pop6     = w_is_count;
                w_res0.kind          = KIND_READING;
                w_res0.reading_kind  = w_which;
                w_res0.reading_value = {w_b[0], w_b[1], w_b[2], w_b[3]};
                w_res0.status_byte   = w_status;
                w_res0.checksum_ok   = ({1'b0, w_sum} == w_csum);
                w_res0.overflow_seen = r_drop;
                w_res0.last          = 1'b1;
                w_push_n             = PUSH_ONE;
                n_drop               = 1'b0;
                n_step               = r_step + 3'd1;
                n_idle               = '0;
            end else begin
                n_idle = w_idle_inc;
                if (w_idle_inc >= r_timeout) begin
                    n_step = r_step + 3'd1;
                    n_idle = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_idle <= '0;
            r_drop <= 1'b0;
        end else begin
            r_step <= n_step;
            r_idle <= n_idle;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= 8'd128;
            r_cmd_sl  <= 7'd18;
            r_cmd_sr  <= 7'd19;
            r_cmd_cl  <= 7'd16;
            r_cmd_cr  <= 7'd17;
            r_timeout <= 16'd100;
            r_mask_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS:  r_addr    <= i_cfg_data[7:0];
                CFG_CMD_SPEED_LEFT:  r_cmd_sl  <= i_cfg_data[6:0];
                CFG_CMD_SPEED_RIGHT: r_cmd_sr  <= i_cfg_data[6:0];
                CFG_CMD_COUNT_LEFT:  r_cmd_cl  <= i_cfg_data[6:0];
                CFG_CMD_COUNT_RIGHT: r_cmd_cr  <= i_cfg_data[6:0];
                CFG_TIMEOUT_TICKS:   r_timeout <= i_cfg_data;
                CFG_MASK_ENABLE:     r_mask_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    esp_rx_chain #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_chain_ctl),
        .o_sts   (w_chain_sts),
        .o_head  (w_head)
    );

    esp_out_queue u_out_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_res0   (w_res0),
        .i_res1   (w_res1),
        .o_space  (w_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_data   (o_out_data)
    );

endmodule

[hdl/esp_fifo_cell.sv]
// one byte cell of the receive chain, loads a new byte or takes one from further down
module esp_fifo_cell (
    input  logic               i_clk,
    input  esp_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]         i_byte,
    input  logic [7:0]         i_d5,
    input  logic [7:0]         i_d6,
    output logic [7:0]         o_q
);
    import esp_pkg::*;

    logic [7:0] r_q;
    logic [7:0] n_q;

    always_comb begin
        n_q = r_q;
        if (i_ctl.load) begin
            n_q = i_byte;
        end else if (i_ctl.shift5) begin
            n_q = i_d5;
        end else if (i_ctl.shift6) begin
            n_q = i_d6;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

[hdl/esp_rx_chain.sv]
// receive byte queue built as a row of shifting cells, oldest byte in cell 0
module esp_rx_chain #(
    parameter int FIFO_DEPTH = esp_pkg::FIFO_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  esp_pkg::t_chain_ctl i_ctl,
    output esp_pkg::t_chain_sts o_sts,
    output logic [5:0][7:0]     o_head
);
    import esp_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    w_q [FIFO_DEPTH];

    genvar gi;
    generate
        for (gi = 0; gi < FIFO_DEPTH; gi++) begin : g_cell
            t_cell_ctl  w_ctl;
            logic [7:0] w_d5;
            logic [7:0] w_d6;

            assign w_ctl.load   = i_ctl.push && (r_count == CW'(gi));
            assign w_ctl.shift5 = i_ctl.pop5;
            assign w_ctl.shift6 = i_ctl.pop6;

            if (gi + 5 < FIFO_DEPTH) begin : g_n5
                assign w_d5 = w_q[gi+5];
            end else begin : g_z5
                assign w_d5 = 8'h00;
            end
            if (gi + 6 < FIFO_DEPTH) begin : g_n6
                assign w_d6 = w_q[gi+6];
            end else begin : g_z6
                assign w_d6 = 8'h00;
            end

            esp_fifo_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_byte (i_ctl.rx_byte),
                .i_d5   (w_d5),
                .i_d6   (w_d6),
                .o_q    (w_q[gi])
            );
        end
        for (gi = 0; gi < 6; gi++) begin : g_head
            assign o_head[gi] = w_q[gi];
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop5) begin
            n_count = r_count - CW'(5);
        end else if (i_ctl.pop6) begin
            n_count = r_count - CW'(6);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_sts.full  = (r_count == CW'(FIFO_DEPTH));
    assign o_sts.have5 = (r_count >= CW'(5));
    assign o_sts.have6 = (r_count >= CW'(6));

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(FIFO_DEPTH))
        else $error("receive chain count beyond depth");
    a_pop5_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop5 |-> (r_count >= CW'(5)))
        else $error("speed reply popped from short chain");
    a_pop6_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop6 |-> (r_count >= CW'(6)))
        else $error("count reply popped from short chain");
    a_push_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> (!i_ctl.pop5 && !i_ctl.pop6 && !o_sts.full))
        else $error("push together with pop or into full chain");
`endif

endmodule

[hdl/esp_out_queue.sv]
// small result queue, takes up to two items a cycle and hands out one when the reader is ready
module esp_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [1:0]         i_push_n,
    input  esp_pkg::t_out_item i_res0,
    input  esp_pkg::t_out_item i_res1,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output esp_pkg::t_out_item o_data
);
    import esp_pkg::*;

    localparam int AW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    t_out_item     r_mem [OQ_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_count;
    logic          w_pop;

    assign w_pop = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + AW'(i_push_n);
        n_rd    = w_pop ? r_rd + AW'(1) : r_rd;
        n_count = r_count + CW'(i_push_n) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_n != PUSH_NONE) begin
            r_mem[r_wr] <= i_res0;
        end
        if (i_push_n == PUSH_TWO) begin
            r_mem[r_wr + AW'(1)] <= i_res1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    // room for the two items a request tick brings
    assign o_space = (r_count <= CW'(OQ_DEPTH - 2));

endmodule
